>>> design/assert_macros.svh
// Assertion macros shared by the ray/sphere intersection design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define RSI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ray/sphere assertion failed");

// Clocked assertion that is also checked during reset.
`define RSI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ray/sphere reset assertion failed");

`endif

>>> design/rsi_pkg.sv
// Shared constants and types of the ray/sphere intersection pipeline.
package rsi_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int FRAC_BITS   = 16;
  localparam int DIST_WIDTH  = 32;

  // Outcome of the root selection, carried alongside the quotient.
  typedef struct packed {
    logic miss;
    logic sat;
  } rsi_flags_t;

endpackage

>>> design/rsi_mul_split.sv
// Two-stage unsigned multiplier built from four half-width partial products.
module rsi_mul_split #(
  parameter int W = 48
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   x,
  input  logic [W-1:0]   y,
  output logic [2*W-1:0] p
);
  localparam int L = W / 2;
  localparam int H = W - L;

  logic [2*L-1:0]   pp00_r;
  logic [L+H-1:0]   pp01_r;
  logic [L+H-1:0]   pp10_r;
  logic [2*H-1:0]   pp11_r;
  logic [2*W-1:0]   p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r <= x[L-1:0] * y[L-1:0];
      pp01_r <= x[L-1:0] * y[W-1:L];
      pp10_r <= x[W-1:L] * y[L-1:0];
      pp11_r <= x[W-1:L] * y[W-1:L];
      p_r    <= (2*W)'(pp00_r) + ((2*W)'(pp01_r) << L) + ((2*W)'(pp10_r) << L)
              + ((2*W)'(pp11_r) << (2*L));
    end
  end

  assign p = p_r;
endmodule

>>> design/rsi_front.sv
// Front stages: dot products, quadratic coefficients and discriminant.
module rsi_front #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [6*CW-1:0]      ray_i,
  input  logic [2*CW-3:0]      rsq_i,
  output logic                 vld_o,
  output logic [6*CW-1:0]      ray_o,
  output logic [2*CW-1:0]      a_o,
  output logic signed [2*CW:0] h_o,
  output logic [4*CW:0]        disc_o,
  output logic                 neg_o
);
  import rsi_pkg::*;

  localparam int AW = 2 * CW;
  localparam int HW = 2 * CW + 1;
  localparam int DW = 4 * CW + 1;

  logic [4:0] v_r;

  logic [CW-1:0]          omag [3];
  logic [CW-1:0]          dmag [3];
  logic signed [CW-1:0]   oc   [3];
  logic signed [CW-1:0]   dc   [3];

  logic [AW-1:0]          dd_r [3];
  logic [AW-1:0]          oo_r [3];
  logic signed [AW-1:0]   do_r [3];
  logic [6*CW-1:0]        ray1_r, ray2_r, ray3_r, ray4_r, ray5_r;

  logic [AW-1:0]          a_r, oos_r, a3_r, a4_r, a5_r;
  logic signed [HW-1:0]   h_r, h3_r, h4_r, h5_r;

  logic [HW-1:0]          hneg;
  logic [AW-1:0]          hm;
  logic [4*CW-1:0]        hh, ar, aq;
  logic [DW:0]            diff;
  logic [DW-1:0]          disc_r;
  logic                   neg_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oc[k]   = ray_i[k*CW +: CW];
      dc[k]   = ray_i[(k+3)*CW +: CW];
      omag[k] = oc[k][CW-1] ? (~oc[k] + 1'b1) : oc[k];
      dmag[k] = dc[k][CW-1] ? (~dc[k] + 1'b1) : dc[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dd_r[k] <= dmag[k] * dmag[k];
        oo_r[k] <= omag[k] * omag[k];
        do_r[k] <= oc[k] * dc[k];
      end
      ray1_r <= ray_i;
      // Three squares of at most 2^(2CW-2) each fit in 2CW bits.
      a_r    <= dd_r[0] + dd_r[1] + dd_r[2];
      oos_r  <= oo_r[0] + oo_r[1] + oo_r[2];
      h_r    <= HW'(do_r[0]) + HW'(do_r[1]) + HW'(do_r[2]);
      ray2_r <= ray1_r;
      ray3_r <= ray2_r;
      a3_r   <= a_r;
      h3_r   <= h_r;
      ray4_r <= ray3_r;
      a4_r   <= a3_r;
      h4_r   <= h3_r;
      ray5_r <= ray4_r;
      a5_r   <= a4_r;
      h5_r   <= h4_r;
      disc_r <= diff[DW-1:0];
      neg_r  <= diff[DW];
    end
  end

  assign hneg = h_r[HW-1] ? (~h_r + 1'b1) : h_r;
  assign hm   = hneg[AW-1:0];

  rsi_mul_split #(.W(AW)) u_hh (.clk(clk), .en(en), .x(hm),  .y(hm),             .p(hh));
  rsi_mul_split #(.W(AW)) u_ar (.clk(clk), .en(en), .x(a_r), .y(AW'(rsq_i)),     .p(ar));
  rsi_mul_split #(.W(AW)) u_aq (.clk(clk), .en(en), .x(a_r), .y(oos_r),          .p(aq));

  // disc = h^2 + a r^2 - a |o|^2; the extra top bit flags a negative result.
  assign diff = (DW+1)'(hh) + (DW+1)'(ar) - (DW+1)'(aq);

  assign vld_o  = v_r[4];
  assign ray_o  = ray5_r;
  assign a_o    = a5_r;
  assign h_o    = h5_r;
  assign disc_o = disc_r;
  assign neg_o  = neg_r;
endmodule

>>> design/rsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt #(
  parameter int SW  = 49,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SBW-1:0]    side_i,
  output logic              vld_o,
  output logic [SW-1:0]     root_o,
  output logic [SBW-1:0]    side_o
);
  import rsi_pkg::*;

  localparam int RW = SW + 3;

  logic [SW-1:0]   v_r;
  logic [RW-1:0]   rem_r   [SW];
  logic [SW-1:0]   root_r  [SW];
  logic [2*SW-1:0] rad_r   [SW];
  logic [SBW-1:0]  side_r  [SW];

  logic [RW-1:0]   src_rem  [SW];
  logic [SW-1:0]   src_root [SW];
  logic [2*SW-1:0] src_rad  [SW];
  logic [SBW-1:0]  src_side [SW];
  logic [RW-1:0]   cand     [SW];
  logic [RW-1:0]   trial    [SW];
  logic [RW-1:0]   rem_nxt  [SW];
  logic [SW-1:0]   root_nxt [SW];

  always_comb begin
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_rad[0]  = rad_i;
    src_side[0] = side_i;
    for (int k = 1; k < SW; k++) begin
      src_rem[k]  = rem_r[k-1];
      src_root[k] = root_r[k-1];
      src_rad[k]  = rad_r[k-1];
      src_side[k] = side_r[k-1];
    end
    for (int k = 0; k < SW; k++) begin
      cand[k]  = {src_rem[k][RW-3:0], src_rad[k][2*SW-1:2*SW-2]};
      trial[k] = RW'({src_root[k], 2'b01});
      if (cand[k] >= trial[k]) begin
        rem_nxt[k]  = cand[k] - trial[k];
        root_nxt[k] = {src_root[k][SW-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = cand[k];
        root_nxt[k] = {src_root[k][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= src_rad[k] << 2;
        side_r[k] <= src_side[k];
      end
    end
  end

  assign vld_o  = v_r[SW-1];
  assign root_o = root_r[SW-1];
  assign side_o = side_r[SW-1];
endmodule

>>> design/rsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rsi_div #(
  parameter int AW  = 48,
  parameter int QW  = 32,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [AW-1:0]   rem0_i,
  input  logic [QW-1:0]   xlo_i,
  input  logic [AW-1:0]   den_i,
  input  logic [SBW-1:0]  side_i,
  output logic            vld_o,
  output logic [QW-1:0]   q_o,
  output logic [SBW-1:0]  side_o
);
  import rsi_pkg::*;

  logic [QW-1:0]  v_r;
  logic [AW-1:0]  rem_r  [QW];
  logic [QW-1:0]  x_r    [QW];
  logic [QW-1:0]  q_r    [QW];
  logic [AW-1:0]  den_r  [QW];
  logic [SBW-1:0] side_r [QW];

  logic [AW-1:0]  src_rem  [QW];
  logic [QW-1:0]  src_x    [QW];
  logic [QW-1:0]  src_q    [QW];
  logic [AW-1:0]  src_den  [QW];
  logic [SBW-1:0] src_side [QW];
  logic [AW:0]    cand     [QW];
  logic [AW:0]    diff     [QW];
  logic           ge       [QW];

  always_comb begin
    src_rem[0]  = rem0_i;
    src_x[0]    = xlo_i;
    src_q[0]    = '0;
    src_den[0]  = den_i;
    src_side[0] = side_i;
    for (int k = 1; k < QW; k++) begin
      src_rem[k]  = rem_r[k-1];
      src_x[k]    = x_r[k-1];
      src_q[k]    = q_r[k-1];
      src_den[k]  = den_r[k-1];
      src_side[k] = side_r[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      cand[k] = {src_rem[k], src_x[k][QW-1]};
      diff[k] = cand[k] - {1'b0, src_den[k]};
      ge[k]   = cand[k] >= {1'b0, src_den[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k]  <= ge[k] ? diff[k][AW-1:0] : cand[k][AW-1:0];
        q_r[k]    <= {src_q[k][QW-2:0], ge[k]};
        x_r[k]    <= src_x[k] << 1;
        den_r[k]  <= src_den[k];
        side_r[k] <= src_side[k];
      end
    end
  end

  assign vld_o  = v_r[QW-1];
  assign q_o    = q_r[QW-1];
  assign side_o = side_r[QW-1];
endmodule

>>> design/rsi_point.sv
// Final stages: distance selection, hit point and output registers.
module rsi_point #(
  parameter int CW = 24,
  parameter int F  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  vld_i,
  input  logic [rsi_pkg::DIST_WIDTH-1:0]        q_i,
  input  rsi_pkg::rsi_flags_t                   flags_i,
  input  logic [6*CW-1:0]                       ray_i,
  output logic                                  vld_o,
  output logic                                  hit_o,
  output logic [rsi_pkg::DIST_WIDTH-1:0]        dist_o,
  output logic signed [CW-1:0]                  px_o,
  output logic signed [CW-1:0]                  py_o,
  output logic signed [CW-1:0]                  pz_o
);
  import rsi_pkg::*;

  localparam int PW  = DIST_WIDTH + 1 + CW;
  localparam int PSW = PW + 1;

  logic [1:0]              v_r;
  logic [DIST_WIDTH-1:0]   t;
  logic [DIST_WIDTH-1:0]   t_r, dist_r;
  logic                    hit1_r, hit_r;
  logic signed [PW-1:0]    prod_r [3];
  logic signed [CW-1:0]    o_r    [3];
  logic signed [CW-1:0]    dc     [3];
  logic signed [PW-1:0]    off    [3];
  logic signed [PSW-1:0]   sum    [3];
  logic signed [CW-1:0]    pc     [3];
  logic signed [CW-1:0]    p_r    [3];

  assign t = flags_i.miss ? '0 : (flags_i.sat ? '1 : q_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dc[k]  = ray_i[(k+3)*CW +: CW];
      // Arithmetic shift floors both signs.
      off[k] = prod_r[k] >>> F;
      sum[k] = PSW'(o_r[k]) + PSW'(off[k]);
      if (sum[k][PSW-1:CW-1] == '0 || sum[k][PSW-1:CW-1] == '1) begin
        pc[k] = sum[k][CW-1:0];
      end else if (sum[k][PSW-1]) begin
        pc[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pc[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= $signed({1'b0, t}) * dc[k];
        o_r[k]    <= ray_i[k*CW +: CW];
        p_r[k]    <= hit1_r ? pc[k] : '0;
      end
      t_r    <= t;
      hit1_r <= ~flags_i.miss;
      dist_r <= t_r;
      hit_r  <= hit1_r;
    end
  end

  assign vld_o  = v_r[1];
  assign hit_o  = hit_r;
  assign dist_o = dist_r;
  assign px_o   = p_r[0];
  assign py_o   = p_r[1];
  assign pz_o   = p_r[2];
endmodule

>>> design/ray_sphere_intersect_top.sv
// Top level of the fixed-point ray/sphere intersection pipeline.
// One ray is accepted per cycle while in_ready is high. The pipeline has 5 front
// stages for the products and the discriminant, 2*COORD_WIDTH+1 square-root stages
// at one root bit each, 2 root-selection stages, 32 divider stages at one quotient
// bit each and 2 hit-point stages. The whole pipeline advances together whenever the
// output register is empty or taken, so in_ready follows out_ready. A radius write
// applies to rays accepted at the same clock edge or later, so it should only be made
// while no ray is in flight.
`include "assert_macros.svh"

module ray_sphere_intersect_top #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH,
  parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [COORD_WIDTH-2:0]              cfg_sphere_radius,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]       in_origin_z,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_x,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_y,
  input  logic signed [COORD_WIDTH-1:0]       in_dir_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [rsi_pkg::DIST_WIDTH-1:0]      out_hit_distance,
  output logic signed [COORD_WIDTH-1:0]       out_point_x,
  output logic signed [COORD_WIDTH-1:0]       out_point_y,
  output logic signed [COORD_WIDTH-1:0]       out_point_z
);
  import rsi_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int RAYW  = 6 * CW;
  localparam int AW    = 2 * CW;
  localparam int HW    = 2 * CW + 1;
  localparam int DW    = 4 * CW + 1;
  localparam int SW    = 2 * CW + 1;
  localparam int NW    = 2 * CW + 3;
  localparam int XW    = NW - 1 + FRAC_BITS;
  localparam int XHW   = XW - DIST_WIDTH;
  localparam int CMW   = (XHW > AW) ? XHW : AW;
  localparam int SB1W  = RAYW + AW + HW + 1;
  localparam int SB2W  = RAYW + 2;
  localparam logic [CW-2:0] RAD_RESET = (CW-1)'(1) << FRAC_BITS;

  logic                en;
  logic [CW-2:0]       radius_r;
  logic [2*CW-3:0]     rsq_r;
  logic [RAYW-1:0]     ray_in;

  logic                fr_vld, fr_neg;
  logic [RAYW-1:0]     fr_ray;
  logic [AW-1:0]       fr_a;
  logic signed [HW-1:0] fr_h;
  logic [DW-1:0]       fr_disc;

  logic                sq_vld;
  logic [SW-1:0]       sq_root;
  logic [SB1W-1:0]     sq_side;
  logic [RAYW-1:0]     sq_ray;
  logic [AW-1:0]       sq_a;
  logic signed [HW-1:0] sq_h;
  logic                sq_neg;
  logic signed [NW-1:0] hx, sx;

  logic                n1v_r;
  logic signed [NW-1:0] n0_r, n1_r;
  logic [RAYW-1:0]     n1ray_r;
  logic [AW-1:0]       n1a_r;
  logic                n1neg_r;

  logic                n0pos, n1pos;
  logic [NW-2:0]       num;
  logic [XW-1:0]       xnum;
  logic [XHW-1:0]      xhi;
  rsi_flags_t          flags;

  logic                n2v_r;
  logic [AW-1:0]       rem0_r, den_r;
  logic [DIST_WIDTH-1:0] xlo_r;
  rsi_flags_t          flags_r;
  logic [RAYW-1:0]     n2ray_r;

  logic                dv_vld;
  logic [DIST_WIDTH-1:0] dv_q;
  logic [SB2W-1:0]     dv_side;
  rsi_flags_t          dv_flags;
  logic [RAYW-1:0]     dv_ray;

  logic                out_zero;

  // The pipeline moves as one unit unless a finished result is held.
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;
  assign ray_in   = {in_dir_z, in_dir_y, in_dir_x, in_origin_z, in_origin_y, in_origin_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_sphere_radius;
    end
  end

  always_ff @(posedge clk) begin
    rsq_r <= radius_r * radius_r;
  end

  rsi_front #(.CW(CW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_valid), .ray_i(ray_in), .rsq_i(rsq_r),
    .vld_o(fr_vld), .ray_o(fr_ray), .a_o(fr_a), .h_o(fr_h), .disc_o(fr_disc), .neg_o(fr_neg)
  );

  rsi_sqrt #(.SW(SW), .SBW(SB1W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(fr_vld), .rad_i({1'b0, fr_disc}),
    .side_i({fr_ray, fr_a, fr_h, fr_neg}),
    .vld_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  assign {sq_ray, sq_a, sq_h, sq_neg} = sq_side;
  assign hx = NW'(sq_h);
  assign sx = NW'(sq_root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1v_r <= 1'b0;
      n2v_r <= 1'b0;
    end else if (en) begin
      n1v_r <= sq_vld;
      n2v_r <= n1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r    <= -hx - sx;
      n1_r    <= -hx + sx;
      n1ray_r <= sq_ray;
      n1a_r   <= sq_a;
      n1neg_r <= sq_neg;
    end
  end

  // The near root is used when it lies ahead of the origin, else the far one.
  assign n0pos      = ~n0_r[NW-1] && (n0_r != '0);
  assign n1pos      = ~n1_r[NW-1] && (n1_r != '0);
  assign num        = n0pos ? n0_r[NW-2:0] : n1_r[NW-2:0];
  assign xnum       = {num, {FRAC_BITS{1'b0}}};
  assign xhi        = xnum[XW-1:DIST_WIDTH];
  assign flags.miss = n1neg_r || (n1a_r == '0) || ~n1pos;
  // The quotient overflows the distance width when the upper numerator part reaches a.
  assign flags.sat  = CMW'(xhi) >= CMW'(n1a_r);

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r  <= AW'(xhi);
      xlo_r   <= xnum[DIST_WIDTH-1:0];
      den_r   <= n1a_r;
      flags_r <= flags;
      n2ray_r <= n1ray_r;
    end
  end

  rsi_div #(.AW(AW), .QW(DIST_WIDTH), .SBW(SB2W)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(n2v_r), .rem0_i(rem0_r), .xlo_i(xlo_r),
    .den_i(den_r), .side_i({n2ray_r, flags_r}),
    .vld_o(dv_vld), .q_o(dv_q), .side_o(dv_side)
  );

  assign {dv_ray, dv_flags} = dv_side;

  rsi_point #(.CW(CW), .F(FRAC_BITS)) u_point (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dv_vld), .q_i(dv_q), .flags_i(dv_flags),
    .ray_i(dv_ray), .vld_o(out_valid), .hit_o(out_hit), .dist_o(out_hit_distance),
    .px_o(out_point_x), .py_o(out_point_y), .pz_o(out_point_z)
  );

  assign out_zero = (out_hit_distance == '0) && (out_point_x == '0) &&
                    (out_point_y == '0) && (out_point_z == '0);

  `RSI_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_zero)
  `RSI_ASSERT(a_dist_hit, clk, rst_n, out_valid && out_hit_distance != '0 |-> out_hit)
  `RSI_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !n1v_r && !n2v_r)

endmodule
